>>> rtl/sdi_pkg.sv
`default_nettype none

package sdi_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_R1    = 2'd2,
        FUNC_EXT   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ACT_CMD   = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_DONE  = 2'd2,
        ACT_DESEL = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        OUT_BUSY       = 3'd0,
        OUT_CMD0_FAIL  = 3'd1,
        OUT_CMD55_ERR  = 3'd2,
        OUT_ACMD41_FAIL = 3'd3,
        OUT_CMD58_FAIL = 3'd4,
        OUT_SD1        = 3'd5,
        OUT_SD2        = 3'd6,
        OUT_SDHC       = 3'd7
    } t_outcome;

    typedef enum logic [3:0] {
        PH_IDLE         = 4'd0,
        PH_CMD0         = 4'd1,
        PH_CMD8_R1      = 4'd2,
        PH_CMD8_EXT     = 4'd3,
        PH_CMD55        = 4'd4,
        PH_ACMD41       = 4'd5,
        PH_CMD58_R1     = 4'd6,
        PH_CMD58_EXT_OK = 4'd7,
        PH_CMD58_EXT_BAD = 4'd8,
        PH_DONE         = 4'd9
    } t_phase;

    localparam logic [5:0]  CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0]  CMD_SEND_IF   = 6'd8;
    localparam logic [5:0]  CMD_APP       = 6'd55;
    localparam logic [5:0]  CMD_SD_OP     = 6'd41;
    localparam logic [5:0]  CMD_READ_OCR  = 6'd58;

    localparam logic [31:0] CMD8_ARG      = 32'h0000_01AA;
    localparam logic [31:0] HCS_BIT       = 32'h4000_0000;
    localparam logic [31:0] TIMEOUT_RESET = 32'd2000;
    localparam logic [7:0]  R1_IDLE       = 8'h01;
    localparam logic [7:0]  R1_READY      = 8'h00;
    localparam int          R1_ILLEGAL_BIT = 2;
    localparam logic [1:0]  OCR_CCS       = 2'b11;

    // result queue, depth must be a power of two
    localparam int OQ_DEPTH = 2;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    typedef struct packed {
        t_action     action;
        logic [5:0]  cmd_index;
        logic [31:0] cmd_arg;
        logic        deselect_after;
        t_outcome    outcome;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    two;
        t_result r0;
        t_result r1;
    } t_bundle;

    typedef struct packed {
        logic    valid;
        t_bundle bundle;
    } t_push;

    function automatic t_result make_res(t_action act, logic [5:0] idx, logic [31:0] arg,
                                         logic desel, t_outcome oc);
        t_result r;
        r.action         = act;
        r.cmd_index      = idx;
        r.cmd_arg        = arg;
        r.deselect_after = desel;
        r.outcome        = oc;
        r.last           = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sdi_core.sv
`default_nettype none

module sdi_core
    import sdi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_resp_byte,
    input  wire logic [31:0] i_ext_word,
    input  wire logic        i_cfg_valid,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_room,
    output t_push            o_push
);

    logic        r_in_valid;
    t_func       r_func;
    logic [7:0]  r_resp;
    logic [31:0] r_ext;

    t_phase      r_phase, n_phase;
    logic [31:0] r_elapsed, n_elapsed;
    logic        r_illegal, n_illegal;
    logic        r_v2, n_v2;
    logic [31:0] r_timeout;

    logic    has_res;
    logic    two;
    t_result res0, res1;
    logic    late;
    logic    advance;

    assign late    = r_elapsed > r_timeout;
    assign advance = r_in_valid && (!has_res || i_room);
    assign o_stall = r_in_valid && !advance;

    assign o_push.valid      = advance && has_res;
    assign o_push.bundle.two = two;
    assign o_push.bundle.r0  = res0;
    assign o_push.bundle.r1  = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_func <= t_func'(i_func);
            r_resp <= i_resp_byte;
            r_ext  <= i_ext_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_elapsed <= '0;
            r_illegal <= 1'b0;
            r_v2      <= 1'b0;
        end else if (advance) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
            r_illegal <= n_illegal;
            r_v2      <= n_v2;
        end
    end

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_illegal = r_illegal;
        n_v2      = r_v2;
        has_res   = 1'b0;
        two       = 1'b0;
        res0      = make_res(ACT_DONE, CMD_GO_IDLE, '0, 1'b0, OUT_BUSY);
        res1      = res0;
        case (r_func)
            FUNC_START: begin
                n_illegal = 1'b0;
                n_v2      = 1'b0;
                n_elapsed = '0;
                n_phase   = PH_CMD0;
                has_res   = 1'b1;
                two       = 1'b1;
                res0      = make_res(ACT_DESEL, CMD_GO_IDLE, '0, 1'b0, OUT_BUSY);
                res0.last = 1'b0;
                res1      = make_res(ACT_CMD, CMD_GO_IDLE, '0, 1'b1, OUT_BUSY);
            end
            FUNC_TICK: begin
                if (r_elapsed != '1) begin
                    n_elapsed = r_elapsed + 32'd1;
                end
            end
            FUNC_R1: begin
                case (r_phase)
                    PH_CMD0: begin
                        has_res = 1'b1;
                        if (r_resp == R1_IDLE) begin
                            n_phase = PH_CMD8_R1;
                            res0    = make_res(ACT_CMD, CMD_SEND_IF, CMD8_ARG, 1'b0, OUT_BUSY);
                        end else if (late) begin
                            n_phase = PH_DONE;
                            res0    = make_res(ACT_DONE, '0, '0, 1'b0, OUT_CMD0_FAIL);
                        end else begin
                            res0    = make_res(ACT_CMD, CMD_GO_IDLE, '0, 1'b1, OUT_BUSY);
                        end
                    end
                    PH_CMD8_R1: begin
                        has_res   = 1'b1;
                        n_illegal = r_resp[R1_ILLEGAL_BIT];
                        n_phase   = PH_CMD8_EXT;
                        res0      = make_res(ACT_FETCH, '0, '0, 1'b1, OUT_BUSY);
                    end
                    PH_CMD55: begin
                        has_res = 1'b1;
                        if (r_resp[7:1] != '0) begin
                            n_phase = PH_DONE;
                            res0    = make_res(ACT_DONE, '0, '0, 1'b0, OUT_CMD55_ERR);
                        end else begin
                            n_phase = PH_ACMD41;
                            res0    = make_res(ACT_CMD, CMD_SD_OP, r_v2 ? HCS_BIT : '0,
                                               1'b1, OUT_BUSY);
                        end
                    end
                    PH_ACMD41: begin
                        has_res = 1'b1;
                        if (r_resp == R1_IDLE && !late) begin
                            n_phase = PH_CMD55;
                            res0    = make_res(ACT_CMD, CMD_APP, '0, 1'b1, OUT_BUSY);
                        end else if (r_resp != R1_READY) begin
                            n_phase = PH_DONE;
                            res0    = make_res(ACT_DONE, '0, '0, 1'b0, OUT_ACMD41_FAIL);
                        end else if (r_v2) begin
                            n_phase = PH_CMD58_R1;
                            res0    = make_res(ACT_CMD, CMD_READ_OCR, '0, 1'b0, OUT_BUSY);
                        end else begin
                            n_phase = PH_DONE;
                            res0    = make_res(ACT_DONE, '0, '0, 1'b0, OUT_SD1);
                        end
                    end
                    PH_CMD58_R1: begin
                        has_res = 1'b1;
                        n_phase = (r_resp == R1_READY) ? PH_CMD58_EXT_OK : PH_CMD58_EXT_BAD;
                        res0    = make_res(ACT_FETCH, '0, '0, 1'b1, OUT_BUSY);
                    end
                    default: begin
                        has_res = 1'b0;
                    end
                endcase
            end
            FUNC_EXT: begin
                case (r_phase)
                    PH_CMD8_EXT: begin
                        has_res   = 1'b1;
                        n_v2      = !r_illegal && (r_ext == CMD8_ARG);
                        n_elapsed = '0;
                        n_phase   = PH_CMD55;
                        res0      = make_res(ACT_CMD, CMD_APP, '0, 1'b1, OUT_BUSY);
                    end
                    PH_CMD58_EXT_OK: begin
                        has_res = 1'b1;
                        n_phase = PH_DONE;
                        res0    = make_res(ACT_DONE, '0, '0, 1'b0,
                                           (r_ext[31:30] == OCR_CCS) ? OUT_SDHC : OUT_SD2);
                    end
                    PH_CMD58_EXT_BAD: begin
                        has_res = 1'b1;
                        n_phase = PH_DONE;
                        res0    = make_res(ACT_DONE, '0, '0, 1'b0, OUT_CMD58_FAIL);
                    end
                    default: begin
                        has_res = 1'b0;
                    end
                endcase
            end
            default: begin
                has_res = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/sdi_out_queue.sv
`default_nettype none

module sdi_out_queue
    import sdi_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    output logic       o_room,
    output logic       o_valid,
    input  wire logic  i_stall,
    output t_result    o_res
);

    t_bundle          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr;
    logic [OQ_AW-1:0] r_rd;
    logic [OQ_AW:0]   r_count;
    logic             r_sub;

    t_bundle head;
    logic    take;
    logic    pop;

    assign head    = r_mem[r_rd];
    assign o_valid = r_count != '0;
    assign o_res   = r_sub ? head.r1 : head.r0;
    assign take    = o_valid && !i_stall;
    // whole entry leaves once its final result is taken
    assign pop     = take && (r_sub || !head.two);
    assign o_room  = (r_count != (OQ_AW+1)'(OQ_DEPTH)) || pop;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
            r_sub   <= 1'b0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + 1'b1;
            end
            if (take) begin
                r_sub <= !pop;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.valid, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/sd_spi_init_sequencer.sv
`default_nettype none

// Channel   Dir  Handshake           Payload
// request   in   i_valid / o_stall   i_func, i_resp_byte, i_ext_word
// result    out  o_valid / i_stall   o_action, o_cmd_index, o_cmd_arg,
//                                    o_deselect_after, o_outcome, o_last
// config    in   i_cfg_valid / o_cfg_ready   i_cfg_data (init_timeout_ticks)
//
// A request is registered, then handled combinationally; its results are written into a
// two-entry queue, which drives the output.
// One request per cycle while not stalled; a start request yields two results,
// presented in turn from one queue entry. Input stalls only when the queue is full.
// Synchronous active-low reset: idle phase, timeout 2000, queue empty.
module sd_spi_init_sequencer
    import sdi_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [7:0]  i_resp_byte,
    input  wire logic [31:0] i_ext_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_action,
    output logic [5:0]       o_cmd_index,
    output logic [31:0]      o_cmd_arg,
    output logic             o_deselect_after,
    output logic [2:0]       o_outcome,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    t_push   push;
    logic    room;
    t_result res;

    assign o_cfg_ready = 1'b1;

    sdi_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_resp_byte (i_resp_byte),
        .i_ext_word  (i_ext_word),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_room      (room),
        .o_push      (push)
    );

    sdi_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (res)
    );

    assign o_action         = res.action;
    assign o_cmd_index      = res.cmd_index;
    assign o_cmd_arg        = res.cmd_arg;
    assign o_deselect_after = res.deselect_after;
    assign o_outcome        = res.outcome;
    assign o_last           = res.last;

endmodule

`default_nettype wire
